@@ rtl/sld_pkg.sv @@
package sld_pkg;

	localparam int NUM_STAGES = 8;

	// Q16.16 and Q2.30 constants
	localparam logic [16:0] Q_ONE      = 17'd65536;
	localparam logic [47:0] EXP_LIMIT  = 48'd786432;
	localparam logic [63:0] LOG2E_Q30  = 64'd1549082005;
	localparam logic [63:0] LN2_Q30    = 64'd744261118;
	localparam logic [63:0] Q30_ONE    = 64'd1073741824;

	// reference rules
	localparam logic [1:0] RULE_SIDE = 2'd0;
	localparam logic [1:0] RULE_ZERO = 2'd1;
	localparam logic [1:0] RULE_OWN  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_GAIN_A     = 3'd0;
	localparam logic [2:0] REG_RATE_B     = 3'd1;
	localparam logic [2:0] REG_BOX_X_LOW  = 3'd2;
	localparam logic [2:0] REG_BOX_X_HIGH = 3'd3;
	localparam logic [2:0] REG_BOX_Y_LOW  = 3'd4;
	localparam logic [2:0] REG_BOX_Y_HIGH = 3'd5;
	localparam logic [2:0] REG_BOX_Z_LOW  = 3'd6;
	localparam logic [2:0] REG_BOX_Z_HIGH = 3'd7;

	// one load enable per pipeline stage, bit k loads stage k
	typedef logic [NUM_STAGES:1] stage_en_t;

	// 2^(i/depth) in Q2.30 from a truncated Taylor series of exp(z), z in Q30
	function automatic logic [31:0] exp_taylor(input logic [63:0] z);
		logic [63:0] term;
		logic [63:0] sum;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (int n = 1; n <= 24; n++) begin
			if (term != 64'd0) begin
				term = ((term * z) >> 30) / 64'(n);
				sum  = sum + term;
			end
		end
		return sum[31:0];
	endfunction

endpackage

@@ rtl/sponge_layer_damping_top.sv @@
// Channel  Handshake             Payload
// in       in_valid / in_stall   pos_x..pos_z, cell_value, ref_*, ref_rule, inv_time_step
// out      out_valid / out_stall source_increment
// cfg      cfg_we                cfg_index, cfg_data
//
// Eight register stages; one transaction enters per cycle while in_stall is low,
// and each result passes through all of them before it leaves.
// The depth is set by the distance multiply, the exp table path and the two
// increment multiplies. A stage holds only while a later full stage is stalled,
// so bubbles are squeezed out. Reset clears stage valids and loads the
// register defaults; there is no clearing pass.
module sponge_layer_damping_top #(
	parameter int NUM_DIMS        = 3,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] cell_value,
	input  logic signed [31:0] ref_x_low,
	input  logic signed [31:0] ref_x_high,
	input  logic signed [31:0] ref_y_low,
	input  logic signed [31:0] ref_y_high,
	input  logic signed [31:0] ref_z_low,
	input  logic signed [31:0] ref_z_high,
	input  logic        [1:0]  ref_rule,
	input  logic        [30:0] inv_time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] source_increment
);

	localparam int NS = sld_pkg::NUM_STAGES;

	logic        [31:0] gain_a_q;
	logic        [31:0] rate_b_q;
	logic signed [31:0] box_lo_q [3];
	logic signed [31:0] box_hi_q [3];

	logic [NS:1]        vld;
	logic [NS+1:1]      rdy;
	sld_pkg::stage_en_t en;

	logic signed [31:0] pos_a    [3];
	logic signed [31:0] rlo_a    [3];
	logic signed [31:0] rhi_a    [3];
	logic               outside  [3];
	logic        [47:0] x_a      [3];
	logic signed [31:0] sref_a   [3];
	logic        [16:0] sigma_a  [3];

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_a_q <= 32'd32768;
			rate_b_q <= 32'd3277;
			for (int a = 0; a < 3; a++) begin
				box_lo_q[a] <= 32'sd0;
				box_hi_q[a] <= 32'sd65536;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				sld_pkg::REG_GAIN_A:     gain_a_q    <= cfg_data;
				sld_pkg::REG_RATE_B:     rate_b_q    <= cfg_data;
				sld_pkg::REG_BOX_X_LOW:  box_lo_q[0] <= cfg_data;
				sld_pkg::REG_BOX_X_HIGH: box_hi_q[0] <= cfg_data;
				sld_pkg::REG_BOX_Y_LOW:  box_lo_q[1] <= cfg_data;
				sld_pkg::REG_BOX_Y_HIGH: box_hi_q[1] <= cfg_data;
				sld_pkg::REG_BOX_Z_LOW:  box_lo_q[2] <= cfg_data;
				sld_pkg::REG_BOX_Z_HIGH: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage flow control: a stage loads when empty or when the next one moves
	always_comb begin
		rdy[NS+1] = !out_stall;
		for (int k = NS; k >= 1; k--)
			rdy[k] = !vld[k] || rdy[k+1];
		en = rdy[NS:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1])
				vld[1] <= in_valid;
			for (int k = 2; k <= NS; k++)
				if (en[k])
					vld[k] <= vld[k-1];
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = vld[NS];

	assign pos_a[0] = pos_x;  assign rlo_a[0] = ref_x_low;  assign rhi_a[0] = ref_x_high;
	assign pos_a[1] = pos_y;  assign rlo_a[1] = ref_y_low;  assign rhi_a[1] = ref_y_high;
	assign pos_a[2] = pos_z;  assign rlo_a[2] = ref_z_low;  assign rhi_a[2] = ref_z_high;

	// per-axis distance and sigma lanes
	for (genvar a = 0; a < 3; a++) begin : g_axis
		if (a < NUM_DIMS) begin : g_used
			sld_dist u_dist (
				.clk      (clk),
				.en       (en),
				.pos      (pos_a[a]),
				.lo       (box_lo_q[a]),
				.hi       (box_hi_q[a]),
				.ref_lo   (rlo_a[a]),
				.ref_hi   (rhi_a[a]),
				.rate_b   (rate_b_q),
				.outside  (outside[a]),
				.x        (x_a[a]),
				.side_ref (sref_a[a])
			);
			sld_sigma #(
				.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
			) u_sigma (
				.clk     (clk),
				.en      (en),
				.outside (outside[a]),
				.x       (x_a[a]),
				.gain_a  (gain_a_q),
				.sigma   (sigma_a[a])
			);
		end else begin : g_unused
			assign outside[a] = 1'b0;
			assign x_a[a]     = 48'd0;
			assign sref_a[a]  = 32'sd0;
			assign sigma_a[a] = 17'd0;
		end
	end

	// carry the item's own fields alongside the lanes
	logic signed [31:0] val_s1, val_s2, val_s3, val_s4, val_s5;
	logic        [1:0]  rule_s1, rule_s2, rule_s3, rule_s4, rule_s5;
	logic        [30:0] dt_s1, dt_s2, dt_s3, dt_s4, dt_s5;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			val_s1 <= cell_value; rule_s1 <= ref_rule; dt_s1 <= inv_time_step;
		end
		if (en[2]) begin
			val_s2 <= val_s1; rule_s2 <= rule_s1; dt_s2 <= dt_s1;
		end
		if (en[3]) begin
			val_s3 <= val_s2; rule_s3 <= rule_s2; dt_s3 <= dt_s2;
		end
		if (en[4]) begin
			val_s4 <= val_s3; rule_s4 <= rule_s3; dt_s4 <= dt_s3;
		end
		if (en[5]) begin
			val_s5 <= val_s4; rule_s5 <= rule_s4; dt_s5 <= dt_s4;
		end
	end

	// choose the reference side: largest exponent, earlier axis on ties
	logic               have;
	logic        [47:0] best_x;
	logic signed [31:0] sel_ref;
	logic signed [31:0] ref_s3, ref_s4, ref_s5;
	logic               any_s3, any_s4, any_s5;

	always_comb begin
		have    = 1'b0;
		best_x  = 48'd0;
		sel_ref = 32'sd0;
		for (int a = 0; a < 3; a++) begin
			if (outside[a] && gain_a_q != 32'd0 && (!have || x_a[a] > best_x)) begin
				have    = 1'b1;
				best_x  = x_a[a];
				sel_ref = sref_a[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ref_s3 <= sel_ref;
			any_s3 <= outside[0] || outside[1] || outside[2];
		end
		if (en[4]) begin
			ref_s4 <= ref_s3; any_s4 <= any_s3;
		end
		if (en[5]) begin
			ref_s5 <= ref_s4; any_s5 <= any_s4;
		end
	end

	sld_incr u_incr (
		.clk              (clk),
		.en               (en),
		.sigma_x          (sigma_a[0]),
		.sigma_y          (sigma_a[1]),
		.sigma_z          (sigma_a[2]),
		.any_out          (any_s5),
		.cell_value       (val_s5),
		.side_ref         (ref_s5),
		.ref_rule         (rule_s5),
		.inv_time_step    (dt_s5),
		.source_increment (source_increment)
	);

endmodule

@@ rtl/sld_dist.sv @@
// Distance past the near bound for one axis, then exponent x = (B*d) >> 16.
module sld_dist (
	input  logic                clk,
	input  sld_pkg::stage_en_t  en,
	input  logic signed [31:0]  pos,
	input  logic signed [31:0]  lo,
	input  logic signed [31:0]  hi,
	input  logic signed [31:0]  ref_lo,
	input  logic signed [31:0]  ref_hi,
	input  logic        [31:0]  rate_b,
	output logic                outside,
	output logic        [47:0]  x,
	output logic signed [31:0]  side_ref
);

	logic               below;
	logic signed [32:0] dd_full;
	logic               out_s1;
	logic        [31:0] dd_s1;
	logic signed [31:0] ref_s1;
	logic        [63:0] prod;
	logic               out_s2;
	logic        [47:0] x_s2;
	logic signed [31:0] ref_s2;

	// classify position against the box and take the absolute distance
	always_comb begin
		below   = pos < lo;
		dd_full = below ? (33'(lo) - 33'(pos)) : (33'(pos) - 33'(hi));
		if (dd_full < 0)
			dd_full = -dd_full;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			out_s1 <= !(pos > lo && pos < hi);
			dd_s1  <= dd_full[31:0];
			ref_s1 <= below ? ref_lo : ref_hi;
		end
	end

	// scale distance by rate
	assign prod = 64'(rate_b) * 64'(dd_s1);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			out_s2 <= out_s1;
			x_s2   <= prod[63:16];
			ref_s2 <= ref_s1;
		end
	end

	assign outside  = out_s2;
	assign x        = x_s2;
	assign side_ref = ref_s2;

endmodule

@@ rtl/sld_sigma.sv @@
// Damping strength sigma = min(A*exp(x), 1.0) through log2 scaling,
// a table of fractional powers of two and a shift.
module sld_sigma #(
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                clk,
	input  sld_pkg::stage_en_t  en,
	input  logic                outside,
	input  logic        [47:0]  x,
	input  logic        [31:0]  gain_a,
	output logic        [16:0]  sigma
);

	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

	logic [31:0] exp_tab [EXP_TABLE_DEPTH];

	// build the table at elaboration
	for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_tab
		localparam logic [63:0] Z = (64'(i) * sld_pkg::LN2_Q30) / EXP_TABLE_DEPTH;
		localparam logic [31:0] TV = sld_pkg::exp_taylor(Z);
		assign exp_tab[i] = TV;
	end

	logic [63:0]      yprod;
	logic             out_s3;
	logic             big_s3;
	logic [20:0]      y_s3;
	logic [31:0]      iprod;
	logic [IDX_W-1:0] idx;
	logic             out_s4;
	logic             big_s4;
	logic [4:0]       k_s4;
	logic [31:0]      t_s4;
	logic [48:0]      shifted;
	logic [50:0]      sprod;
	logic [16:0]      sig_next;
	logic [16:0]      sigma_s5;

	// convert to base two
	assign yprod = 64'(x[19:0]) * sld_pkg::LOG2E_Q30;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			out_s3 <= outside;
			big_s3 <= x >= sld_pkg::EXP_LIMIT;
			y_s3   <= yprod[50:30];
		end
	end

	// look up the fractional power
	assign iprod = 32'(y_s3[15:0]) * 32'(EXP_TABLE_DEPTH);
	assign idx   = iprod[16 +: IDX_W];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			out_s4 <= out_s3;
			big_s4 <= big_s3;
			k_s4   <= y_s3[20:16];
			t_s4   <= exp_tab[idx];
		end
	end

	// apply integer power, scale by amplitude, clamp to one
	always_comb begin
		shifted = 49'(t_s4) << k_s4;
		sprod   = 51'(gain_a[15:0]) * 51'(shifted[48:14]);
		if (!out_s4 || gain_a == 32'd0)
			sig_next = 17'd0;
		else if (gain_a >= 32'(sld_pkg::Q_ONE) || big_s4)
			sig_next = sld_pkg::Q_ONE;
		else if (sprod[50:16] > 35'(sld_pkg::Q_ONE))
			sig_next = sld_pkg::Q_ONE;
		else
			sig_next = sprod[32:16];
	end

	always_ff @(posedge clk) begin
		if (en[5])
			sigma_s5 <= sig_next;
	end

	assign sigma = sigma_s5;

endmodule

@@ rtl/sld_incr.sv @@
// Largest sigma, reference rule, and the scaled, saturated increment.
module sld_incr (
	input  logic                clk,
	input  sld_pkg::stage_en_t  en,
	input  logic        [16:0]  sigma_x,
	input  logic        [16:0]  sigma_y,
	input  logic        [16:0]  sigma_z,
	input  logic                any_out,
	input  logic signed [31:0]  cell_value,
	input  logic signed [31:0]  side_ref,
	input  logic        [1:0]   ref_rule,
	input  logic        [30:0]  inv_time_step,
	output logic signed [31:0]  source_increment
);

	logic        [16:0] smax;
	logic signed [31:0] ref_val;
	logic signed [32:0] diff;
	logic        [32:0] mag;
	logic        [16:0] smax_s6;
	logic        [32:0] mag_s6;
	logic               pos_s6;
	logic               any_s6;
	logic        [30:0] dt_s6;
	logic        [49:0] p1prod;
	logic        [32:0] p1_s7;
	logic               pos_s7;
	logic               any_s7;
	logic        [30:0] dt_s7;
	logic        [63:0] p2prod;
	logic        [31:0] res_next;
	logic signed [31:0] res_s8;

	// pick the largest sigma and the reference, form the difference
	always_comb begin
		smax = sigma_x;
		if (sigma_y > smax)
			smax = sigma_y;
		if (sigma_z > smax)
			smax = sigma_z;
		case (ref_rule)
			sld_pkg::RULE_ZERO: ref_val = 32'sd0;
			sld_pkg::RULE_OWN:  ref_val = cell_value;
			default:            ref_val = side_ref;
		endcase
		diff = 33'(cell_value) - 33'(ref_val);
		mag  = (diff < 0) ? 33'(-diff) : 33'(diff);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			smax_s6 <= smax;
			mag_s6  <= mag;
			pos_s6  <= diff > 0;
			any_s6  <= any_out;
			dt_s6   <= inv_time_step;
		end
	end

	// damp the difference
	assign p1prod = 50'(smax_s6) * 50'(mag_s6);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			p1_s7  <= p1prod[48:16];
			pos_s7 <= pos_s6;
			any_s7 <= any_s6;
			dt_s7  <= dt_s6;
		end
	end

	// scale by the inverse time step and saturate with the opposite sign
	always_comb begin
		p2prod = 64'(p1_s7) * 64'(dt_s7);
		if (!any_s7)
			res_next = 32'd0;
		else if (pos_s7) begin
			if (p2prod[63:16] > 48'h8000_0000)
				res_next = 32'h8000_0000;
			else
				res_next = 32'd0 - p2prod[47:16];
		end else begin
			if (p2prod[63:16] > 48'h7FFF_FFFF)
				res_next = 32'h7FFF_FFFF;
			else
				res_next = p2prod[47:16];
		end
	end

	always_ff @(posedge clk) begin
		if (en[8])
			res_s8 <= res_next;
	end

	assign source_increment = res_s8;

endmodule
